// ===== src/cwr_pkg.sv =====
`timescale 1ns / 1ps
package cwr_pkg;

  localparam int MAX_COLUMNS  = 1024;
  localparam int COL_BITS     = $clog2(MAX_COLUMNS);
  localparam int COUNT_BITS   = COL_BITS + 1;
  localparam int ROW_BITS     = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int ACC_BITS     = 48;
  localparam int FRAC_SHIFT   = 8;
  localparam int SQUARE_BITS  = 2 * SAMPLE_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int OP_BITS        = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_REDUCE_OP    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ELEMENT_OP   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 2'd3;

  localparam logic [OP_BITS-1:0] REDUCE_SUM = 2'd0;
  localparam logic [OP_BITS-1:0] REDUCE_MIN = 2'd1;
  localparam logic [OP_BITS-1:0] REDUCE_MAX = 2'd2;

  localparam logic [OP_BITS-1:0] ELEM_IDENTITY = 2'd0;
  localparam logic [OP_BITS-1:0] ELEM_ABS      = 2'd1;
  localparam logic [OP_BITS-1:0] ELEM_SQUARE   = 2'd2;

  localparam int OUT_DEPTH      = 4;
  localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
  localparam int OUT_COUNT_BITS = OUT_PTR_BITS + 1;

  typedef struct packed {
    logic [COL_BITS-1:0]        column_index;
    logic signed [ACC_BITS-1:0] reduced_value;
    logic                       last_column;
  } cwr_result_t;

endpackage

// ===== src/cwr_in_if.sv =====
`timescale 1ns / 1ps
interface cwr_in_if;
  import cwr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

// ===== src/cwr_out_if.sv =====
`timescale 1ns / 1ps
interface cwr_out_if;
  import cwr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [COL_BITS-1:0]        column_index;
  logic signed [ACC_BITS-1:0] reduced_value;
  logic                       last_column;

  modport source (output valid, output column_index, output reduced_value,
                  output last_column, input ready);
  modport sink   (input valid, input column_index, input reduced_value,
                  input last_column, output ready);

endinterface

// ===== src/column_wise_reduction.sv =====
// channel   | dir | words                          | handshake
// samples   | in  | sample (Q8.8)                  | valid/ready
// results   | out | column_index, reduced_value,   | valid/ready
//           |     | last_column                    |
// cfg       | in  | cfg_index, cfg_data            | cfg_we, no wait
// One word per cycle while samples.ready is high; each word passes an accumulator read, then a fold and write.
// A result reaches results after the last-row word passes the b stage registers and is written into the output buffer.
// Throughput is set by the single read-modify-write port pair of the accumulator RAM.
// Reset (rst, synchronous) clears positions and the four-word output buffer and returns config to its defaults.
// samples.ready drops only when the output buffer plus a last-row word in flight fill four slots.
`timescale 1ns / 1ps
module column_wise_reduction (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cwr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cwr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  cwr_in_if.sink                              samples,
  cwr_out_if.source                           results
);
  import cwr_pkg::*;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic [OP_BITS-1:0]    reduce_op;
  logic [OP_BITS-1:0]    element_op;
  logic [COUNT_BITS-1:0] column_count;
  logic [ROW_BITS-1:0]   row_count;

  logic [COL_BITS-1:0]   column_position;
  logic [ROW_BITS-1:0]   row_position;
  logic [COL_BITS-1:0]   cols_m1;
  logic [ROW_BITS-1:0]   rows_m1;
  logic                  last_col;
  logic                  last_row;
  logic                  accept;

  logic [SAMPLE_BITS-1:0]       magnitude;
  logic [SQUARE_BITS-1:0]       square;
  logic signed [ACC_BITS-1:0]   elem;

  logic                         b_valid;
  logic [COL_BITS-1:0]          b_col;
  logic signed [ACC_BITS-1:0]   b_elem;
  logic                         b_first;
  logic                         b_last_row;
  logic                         b_last_col;
  logic                         fwd_hit;
  logic signed [ACC_BITS-1:0]   fwd_data;
  logic signed [ACC_BITS-1:0]   ram_rdata;
  logic signed [ACC_BITS-1:0]   old_acc;
  logic signed [ACC_BITS:0]     sum_wide;
  logic signed [ACC_BITS-1:0]   sum_sat;
  logic signed [ACC_BITS-1:0]   b_acc;

  logic                         push;
  logic                         pop;
  logic                         b_pend;
  cwr_result_t                  push_word;
  cwr_result_t                  head;
  logic                         head_valid;
  logic [OUT_COUNT_BITS-1:0]    buf_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_op    <= REDUCE_SUM;
      element_op   <= ELEM_IDENTITY;
      column_count <= COUNT_BITS'(1);
      row_count    <= ROW_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REDUCE_OP:    reduce_op    <= cfg_data[OP_BITS-1:0];
        REG_ELEMENT_OP:   element_op   <= cfg_data[OP_BITS-1:0];
        REG_COLUMN_COUNT: column_count <= cfg_data[COUNT_BITS-1:0];
        REG_ROW_COUNT:    row_count    <= cfg_data[ROW_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    priority if (column_count == '0) begin
      cols_m1 = '0;
    end else if (column_count > COUNT_BITS'(MAX_COLUMNS)) begin
      cols_m1 = COL_BITS'(MAX_COLUMNS - 1);
    end else begin
      cols_m1 = COL_BITS'(column_count - COUNT_BITS'(1));
    end
    rows_m1 = (row_count == '0) ? '0 : row_count - ROW_BITS'(1);
  end

  assign last_col = (column_position >= cols_m1);
  assign last_row = (row_position >= rows_m1);
  assign accept   = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_position <= '0;
        row_position    <= last_row ? '0 : row_position + ROW_BITS'(1);
      end else begin
        column_position <= column_position + COL_BITS'(1);
      end
    end
  end

  assign magnitude = samples.sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samples.sample)
                                                   : samples.sample;
  assign square    = magnitude * magnitude;

  always_comb begin
    unique case (element_op)
      ELEM_ABS:    elem = {{(ACC_BITS-SAMPLE_BITS-FRAC_SHIFT){1'b0}}, magnitude,
                           {FRAC_SHIFT{1'b0}}};
      ELEM_SQUARE: elem = {{(ACC_BITS-SQUARE_BITS){1'b0}}, square};
      default:     elem = {{(ACC_BITS-SAMPLE_BITS-FRAC_SHIFT){samples.sample[SAMPLE_BITS-1]}},
                           samples.sample, {FRAC_SHIFT{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    fwd_hit  <= b_valid && (b_col == column_position);
    fwd_data <= b_acc;
    if (accept) begin
      b_col      <= column_position;
      b_elem     <= elem;
      b_first    <= (row_position == '0);
      b_last_row <= last_row;
      b_last_col <= last_col;
    end
  end

  cwr_ram #(
    .WIDTH (ACC_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (b_acc),
    .raddr (column_position),
    .rdata (ram_rdata)
  );

  assign old_acc  = fwd_hit ? fwd_data : ram_rdata;
  assign sum_wide = {old_acc[ACC_BITS-1], old_acc} + {b_elem[ACC_BITS-1], b_elem};

  always_comb begin
    if (sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1]) begin
      sum_sat = sum_wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_BITS-1:0];
    end
  end

  always_comb begin
    if (b_first) begin
      b_acc = b_elem;
    end else begin
      unique case (reduce_op)
        REDUCE_MIN: b_acc = (b_elem < old_acc) ? b_elem : old_acc;
        REDUCE_MAX: b_acc = (b_elem > old_acc) ? b_elem : old_acc;
        default:    b_acc = sum_sat;
      endcase
    end
  end

  assign b_pend    = b_valid && b_last_row;
  assign push      = b_pend;
  assign push_word = '{column_index: b_col, reduced_value: b_acc, last_column: b_last_col};
  assign pop       = results.valid && results.ready;

  cwr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (buf_count)
  );

  assign samples.ready         = (buf_count + OUT_COUNT_BITS'(b_pend))
                                 < OUT_COUNT_BITS'(OUT_DEPTH);
  assign results.valid         = head_valid;
  assign results.column_index  = head.column_index;
  assign results.reduced_value = head.reduced_value;
  assign results.last_column   = head.last_column;

`ifndef NO_ASSERTIONS
  a_fwd_same_column: assert property (@(posedge clk) disable iff (rst)
    (b_valid && $past(b_valid) && (b_col == $past(b_col))) |-> fwd_hit)
    else $error("back-to-back update of one column not forwarded");

  a_buf_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && (buf_count == OUT_COUNT_BITS'(OUT_DEPTH))) |-> pop)
    else $error("output buffer overflow");

  a_reserve_bound: assert property (@(posedge clk) disable iff (rst)
    (buf_count + OUT_COUNT_BITS'(b_pend)) <= OUT_COUNT_BITS'(OUT_DEPTH))
    else $error("reserved output slots exceed buffer depth");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!results.valid && !b_valid))
    else $error("activity straight after reset");
`endif

endmodule

// ===== src/cwr_ram.sv =====
`timescale 1ns / 1ps
module cwr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cwr_out_buf.sv =====
`timescale 1ns / 1ps
module cwr_out_buf (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  cwr_pkg::cwr_result_t                push_word,
  input  logic                                pop,
  output logic                                head_valid,
  output cwr_pkg::cwr_result_t                head,
  output logic [cwr_pkg::OUT_COUNT_BITS-1:0]  count
);
  import cwr_pkg::*;

  cwr_result_t               slots [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0]   wr_ptr;
  logic [OUT_PTR_BITS-1:0]   rd_ptr;
  logic [OUT_COUNT_BITS-1:0] count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + OUT_COUNT_BITS'(1);
    end else if (pop && !push) begin
      count_next = count - OUT_COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_BITS'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

endmodule
